### rtl/lpg_pkg.sv
// Package for the line pixel generator: shared constants, register indexes,
// the back-end state type and the job width helper.
// No dependencies.
`default_nettype none

package lpg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int ADDR_BITS_DEFAULT  = 48;

   localparam int PITCH_BITS  = 13;
   localparam int COLOR_BITS  = 24;
   localparam int CHAN_BITS   = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd1024;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;

   // Register select is the 8-byte word index of the address.
   typedef enum logic [0:0] {
      CSR_FRAME_BASE = 1'b0,
      CSR_LINE_PITCH = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_LINE_START = 1'b0,
      REQ_TICK       = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_YSUM,
      BK_AMUL,
      BK_AADD
   } back_state_type;

   // Job layout: vertical flag, last flag, x, y base, t, dy (one extra bit),
   // dx and the packed colour.
   function automatic int job_bits(input int coord_bits);
      return 2 + 4 * coord_bits + (coord_bits + 1) + COLOR_BITS;
   endfunction

endpackage

`default_nettype wire

### rtl/lpg_queue.sv
// Small job queue between the line front end and the pixel back end.
// Depends on lpg_pkg for the queue depth.
`default_nettype none

module lpg_queue
   import lpg_pkg::*;
#(
   parameter int WIDTH = job_bits(COORD_BITS_DEFAULT)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic      [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/lpg_front.sv
// Front end of the line pixel generator: takes request beats, holds the
// active line and turns each tick into a pixel job. Depends on lpg_pkg.
`default_nettype none

module lpg_front
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_type,
   input  wire logic [COORD_BITS-1:0]             req_start_x,
   input  wire logic [COORD_BITS-1:0]             req_start_y,
   input  wire logic [COORD_BITS-1:0]             req_end_x,
   input  wire logic [COORD_BITS-1:0]             req_end_y,
   input  wire logic [CHAN_BITS-1:0]              req_red,
   input  wire logic [CHAN_BITS-1:0]              req_green,
   input  wire logic [CHAN_BITS-1:0]              req_blue,
   output logic                                   job_push,
   output logic [job_bits(COORD_BITS)-1:0]        job_data,
   input  wire logic                              job_full
);

   localparam int CB = COORD_BITS;

   typedef struct packed {
      logic                  vert;
      logic                  last;
      logic [CB-1:0]         x;
      logic [CB-1:0]         ybase;
      logic [CB-1:0]         t;
      logic [CB:0]           dy;
      logic [CB-1:0]         dx;
      logic [COLOR_BITS-1:0] colour;
   } job_type;

   logic                  busy_ff, busy_in;
   logic                  vert_ff, vert_in;
   logic [CB-1:0]         step_ff, step_in;
   logic [CB-1:0]         stop_ff, stop_in;
   logic [CB-1:0]         ox_ff, ox_in;
   logic [CB-1:0]         oy_ff, oy_in;
   logic [CB-1:0]         dx_ff, dx_in;
   logic [CB:0]           dy_ff, dy_in;
   logic [COLOR_BITS-1:0] colour_ff, colour_in;

   logic                  accept;
   logic                  is_start;
   logic [CB-1:0]         step_next;
   job_type               job;

   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;
   assign is_start  = (req_type == REQ_LINE_START);
   assign step_next = step_ff + 1'b1;

   always_comb begin
      job.vert   = vert_ff;
      job.last   = (step_next == stop_ff);
      job.x      = vert_ff ? ox_ff : step_ff;
      job.ybase  = vert_ff ? step_ff : oy_ff;
      job.t      = step_ff - ox_ff;
      job.dy     = dy_ff;
      job.dx     = dx_ff;
      job.colour = colour_ff;
   end

   assign job_push = accept && !is_start && busy_ff;
   assign job_data = job;

   always_comb begin
      busy_in   = busy_ff;
      vert_in   = vert_ff;
      step_in   = step_ff;
      stop_in   = stop_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      colour_in = colour_ff;
      if (accept && is_start) begin
         ox_in     = req_start_x;
         oy_in     = req_start_y;
         dx_in     = req_end_x - req_start_x;
         dy_in     = {1'b0, req_end_y} - {1'b0, req_start_y};
         colour_in = {req_red, req_green, req_blue};
         if (req_start_x != req_end_x) begin
            vert_in = 1'b0;
            step_in = req_start_x;
            stop_in = req_end_x;
            busy_in = (req_end_x > req_start_x);
         end else begin
            vert_in = 1'b1;
            step_in = req_start_y;
            stop_in = req_end_y;
            busy_in = (req_end_y > req_start_y);
         end
      end else if (job_push) begin
         step_in = step_next;
         if (job.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      vert_ff   <= vert_in;
      step_ff   <= step_in;
      stop_ff   <= stop_in;
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      colour_ff <= colour_in;
   end

endmodule

`default_nettype wire

### rtl/lpg_back.sv
// Back end of the line pixel generator: works out y with a serial divider,
// forms the framebuffer address and holds the result register. Depends on lpg_pkg.
`default_nettype none

module lpg_back
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int ADDR_BITS  = ADDR_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_valid,
   input  wire logic [job_bits(COORD_BITS)-1:0] job_data,
   output logic                               job_pop,
   input  wire logic [ADDR_BITS-1:0]          frame_base,
   input  wire logic [PITCH_BITS-1:0]         line_pitch,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [ADDR_BITS-1:0]               rsp_write_address,
   output logic [COLOR_BITS-1:0]              rsp_write_word,
   output logic [COORD_BITS-1:0]              rsp_pixel_x,
   output logic [COORD_BITS-1:0]              rsp_pixel_y,
   output logic                               rsp_last_pixel
);

   localparam int CB       = COORD_BITS;
   localparam int PB       = 2 * CB;
   localparam int CNT_BITS = (CB > 1) ? $clog2(CB) : 1;
   localparam int PM_BITS  = PITCH_BITS + CB;
   localparam int SUM_BITS = (ADDR_BITS > PM_BITS + 2) ? ADDR_BITS : PM_BITS + 2;

   typedef struct packed {
      logic                  vert;
      logic                  last;
      logic [CB-1:0]         x;
      logic [CB-1:0]         ybase;
      logic [CB-1:0]         t;
      logic [CB:0]           dy;
      logic [CB-1:0]         dx;
      logic [COLOR_BITS-1:0] colour;
   } job_type;

   back_state_type        state_ff, state_in;
   job_type               job_ff, job_in;
   logic [CB-1:0]         y_ff, y_in;
   logic                  neg_ff, neg_in;
   logic [CB-1:0]         rem_ff, rem_in;
   logic [PB-1:0]         quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PM_BITS-1:0]    pm_ff, pm_in;
   logic [ADDR_BITS-1:0]  bx_ff, bx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [ADDR_BITS-1:0]  out_addr_ff, out_addr_in;
   logic [COLOR_BITS-1:0] out_word_ff, out_word_in;
   logic [CB-1:0]         out_x_ff, out_x_in;
   logic [CB-1:0]         out_y_ff, out_y_in;
   logic                  out_last_ff, out_last_in;

   job_type               job_head;
   logic                  div_done;
   logic                  slot_free;
   logic                  load_out;
   logic [CB:0]           dy_neg;
   logic [CB-1:0]         dy_mag;
   logic [CB:0]           rem_shift0, rem_shift1;
   logic [CB-1:0]         rem_mid, rem_step;
   logic [PB-1:0]         quo_mid, quo_step;
   logic [CB-1:0]         q_low, y_off;
   logic [SUM_BITS-1:0]   addr_sum;

   assign job_head  = job_data;
   assign div_done  = (cnt_ff == CNT_BITS'(CB - 1));
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign dy_neg    = ~job_ff.dy + 1'b1;
   assign dy_mag    = job_ff.dy[CB] ? dy_neg[CB-1:0] : job_ff.dy[CB-1:0];

   // Two restoring division steps per cycle; the remainder stays below dx.
   always_comb begin
      rem_shift0 = {rem_ff, quo_ff[PB-1]};
      quo_mid    = {quo_ff[PB-2:0], 1'b0};
      rem_mid    = rem_shift0[CB-1:0];
      if (rem_shift0 >= {1'b0, job_ff.dx}) begin
         rem_mid    = CB'(rem_shift0 - {1'b0, job_ff.dx});
         quo_mid[0] = 1'b1;
      end
      rem_shift1 = {rem_mid, quo_mid[PB-1]};
      quo_step   = {quo_mid[PB-2:0], 1'b0};
      rem_step   = rem_shift1[CB-1:0];
      if (rem_shift1 >= {1'b0, job_ff.dx}) begin
         rem_step    = CB'(rem_shift1 - {1'b0, job_ff.dx});
         quo_step[0] = 1'b1;
      end
   end

   // The quotient is below |dy|, so its low half holds it whole.
   assign q_low    = quo_ff[CB-1:0];
   assign y_off    = neg_ff ? (~q_low + 1'b1) : q_low;
   assign addr_sum = SUM_BITS'(bx_ff) + SUM_BITS'({pm_ff, 2'b00});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = job_head.vert ? BK_AMUL : BK_MUL;
            end
         end
         BK_MUL:  state_in = BK_DIV;
         BK_DIV: begin
            if (div_done) begin
               state_in = BK_YSUM;
            end
         end
         BK_YSUM: state_in = BK_AMUL;
         BK_AMUL: state_in = BK_AADD;
         BK_AADD: begin
            if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      job_pop  = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: job_pop  = job_valid;
         BK_AADD: load_out = slot_free;
         default: begin
            job_pop  = 1'b0;
            load_out = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      job_in  = job_ff;
      y_in    = y_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      pm_in   = pm_ff;
      bx_in   = bx_ff;
      if (job_pop) begin
         job_in = job_head;
         y_in   = job_head.ybase;
      end
      case (state_ff)
         BK_MUL: begin
            neg_in = job_ff.dy[CB];
            quo_in = PB'(dy_mag) * PB'(job_ff.t);
            rem_in = '0;
            cnt_in = '0;
         end
         BK_DIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            cnt_in = cnt_ff + 1'b1;
         end
         BK_YSUM: y_in = job_ff.ybase + y_off;
         BK_AMUL: begin
            pm_in = PM_BITS'(line_pitch) * PM_BITS'(y_ff);
            bx_in = frame_base + ADDR_BITS'({job_ff.x, 2'b00});
         end
         default: begin
            rem_in = rem_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_addr_in  = out_addr_ff;
      out_word_in  = out_word_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_addr_in  = addr_sum[ADDR_BITS-1:0];
         out_word_in  = job_ff.colour;
         out_x_in     = job_ff.x;
         out_y_in     = y_ff;
         out_last_in  = job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      y_ff        <= y_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      pm_ff       <= pm_in;
      bx_ff       <= bx_in;
      out_addr_ff <= out_addr_in;
      out_word_ff <= out_word_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_write_address = out_addr_ff;
   assign rsp_write_word    = out_word_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_last_pixel    = out_last_ff;

endmodule

`default_nettype wire

### rtl/line_pixel_generator_core.sv
// Line pixel generator: a start beat latches a line, and each tick beat that
// follows produces one framebuffer write for the next pixel of that line.
//
// Request channel (req_*): valid/stall. A start beat (req_type 0) is taken
// by the front end and produces no response. A tick beat with a line
// active becomes a job in a two-entry queue; a tick with no line is dropped.
// req_stall is high only while that queue is full.
// Response channel (rsp_*): valid/stall, one beat per pixel, fed from an
// output register, so the back end starts the next pixel while a response
// waits. A stalled response holds its payload until taken.
// The back end handles one pixel at a time. A sloped pixel runs the states
// MUL, DIV, YSUM, AMUL and AADD, with a serial divider that retires two
// quotient bits per cycle; a pixel of a vertical line goes straight to AMUL
// and AADD. It takes the next job from the queue only once the previous
// pixel has gone to the output register.
// CSR port: APB style, 64-bit data; frame_base at 0x0, line_pitch at 0x8.
// Reset (synchronous) clears the line, the queue and the response register,
// sets frame_base to 0 and line_pitch to 1024.
// Depends on lpg_pkg, lpg_front, lpg_queue and lpg_back.
`default_nettype none

module line_pixel_generator_core
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int ADDR_BITS  = ADDR_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_type,
   input  wire logic [COORD_BITS-1:0]    req_start_x,
   input  wire logic [COORD_BITS-1:0]    req_start_y,
   input  wire logic [COORD_BITS-1:0]    req_end_x,
   input  wire logic [COORD_BITS-1:0]    req_end_y,
   input  wire logic [CHAN_BITS-1:0]     req_red,
   input  wire logic [CHAN_BITS-1:0]     req_green,
   input  wire logic [CHAN_BITS-1:0]     req_blue,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [ADDR_BITS-1:0]          rsp_write_address,
   output logic [COLOR_BITS-1:0]         rsp_write_word,
   output logic [COORD_BITS-1:0]         rsp_pixel_x,
   output logic [COORD_BITS-1:0]         rsp_pixel_y,
   output logic                          rsp_last_pixel,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   localparam int JOB_BITS = job_bits(COORD_BITS);

   logic [ADDR_BITS-1:0]  base_ff, base_in;
   logic [PITCH_BITS-1:0] pitch_ff, pitch_in;
   logic                  csr_write;
   csr_index_type         csr_sel;

   logic                  job_push;
   logic [JOB_BITS-1:0]   job_data;
   logic                  job_full;
   logic                  job_pop;
   logic                  head_valid;
   logic [JOB_BITS-1:0]   head_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_sel    = csr_index_type'(csr_paddr[3]);

   always_comb begin
      base_in  = base_ff;
      pitch_in = pitch_ff;
      if (csr_write) begin
         case (csr_sel)
            CSR_FRAME_BASE: base_in  = csr_pwdata[ADDR_BITS-1:0];
            CSR_LINE_PITCH: pitch_in = csr_pwdata[PITCH_BITS-1:0];
            default:        base_in  = base_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_FRAME_BASE: csr_prdata = CSR_DATA_BITS'(base_ff);
         CSR_LINE_PITCH: csr_prdata = CSR_DATA_BITS'(pitch_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pitch_ff <= PITCH_RESET;
      end else begin
         base_ff  <= base_in;
         pitch_ff <= pitch_in;
      end
   end

   lpg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .job_push    (job_push),
      .job_data    (job_data),
      .job_full    (job_full)
   );

   lpg_queue #(
      .WIDTH (JOB_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   lpg_back #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (head_valid),
      .job_data          (head_data),
      .job_pop           (job_pop),
      .frame_base        (base_ff),
      .line_pitch        (pitch_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_write_word    (rsp_write_word),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

`default_nettype wire

### bench/line_pixel_generator_core_tb.sv
// Self-checking testbench for line_pixel_generator_core: drives start and tick
// beats, writes the frame registers over the APB port and predicts every write.
// Depends on lpg_pkg and the line_pixel_generator_core RTL.
`default_nettype none

module line_pixel_generator_core_tb
   import lpg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEFAULT;
   localparam int AB = ADDR_BITS_DEFAULT;
   localparam int RANDOM_BEATS = 500;
   localparam int PHASE_BEATS = 100;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      req_kind_type          kind;
      logic [CB-1:0]         start_x;
      logic [CB-1:0]         start_y;
      logic [CB-1:0]         end_x;
      logic [CB-1:0]         end_y;
      logic [CHAN_BITS-1:0]  red;
      logic [CHAN_BITS-1:0]  green;
      logic [CHAN_BITS-1:0]  blue;
   } req_beat_type;

   typedef struct packed {
      logic [AB-1:0]         addr;
      logic [COLOR_BITS-1:0] word;
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic                  last;
   } pixel_write_type;

   // A row with fixed set carries its own answer: has_write says whether a
   // pixel write is due at all, and px gives it.
   typedef struct packed {
      req_beat_type    beat;
      logic            fixed;
      logic            has_write;
      pixel_write_type px;
   } directed_row_type;

   localparam int DIR_ROWS = 25;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_type;
   logic [CB-1:0] req_start_x;
   logic [CB-1:0] req_start_y;
   logic [CB-1:0] req_end_x;
   logic [CB-1:0] req_end_y;
   logic [CHAN_BITS-1:0] req_red;
   logic [CHAN_BITS-1:0] req_green;
   logic [CHAN_BITS-1:0] req_blue;
   logic rsp_valid;
   logic rsp_stall;
   logic [AB-1:0] rsp_write_address;
   logic [COLOR_BITS-1:0] rsp_write_word;
   logic [CB-1:0] rsp_pixel_x;
   logic [CB-1:0] rsp_pixel_y;
   logic rsp_last_pixel;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   line_pixel_generator_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_write_address(rsp_write_address),
      .rsp_write_word(rsp_write_word),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_last_pixel(rsp_last_pixel),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow of the rasterizer: register copies and the active line.
   logic [AB-1:0]         shadow_base;
   logic [PITCH_BITS-1:0] shadow_pitch;
   logic                  line_active;
   logic                  line_vertical;
   logic [CB-1:0]         line_step;
   logic [CB-1:0]         line_origin_x;
   logic [CB-1:0]         line_origin_y;
   logic [CB-1:0]         line_stop;
   logic [CB-1:0]         line_dx;
   logic [CB:0]           line_dy;
   logic [COLOR_BITS-1:0] line_colour;

   pixel_write_type pending_writes[$];
   pixel_write_type oldest_write;
   int  mismatch_count = 0;
   bit  quiet = 0;
   bit  hold_off = 0;
   int  beats_counted = 0;
   int  stall_left = 0;

   directed_row_type directed_rows [0:DIR_ROWS-1] = '{
      '{'{REQ_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'h000, 12'h000, 12'h000, 12'h000, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'hFF, 8'h00, 8'h80},
        1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'hABC, 12'h123, 12'h456, 12'h789, 8'h11, 8'h22, 8'h33},
        1'b1, 1'b1, '{48'd0, 24'hFF0080, 12'd0, 12'd0, 1'b0}},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      // A new start drops the diagonal that is still in progress.
      '{'{REQ_LINE_START, 12'd4094, 12'd4095, 12'd4095, 12'd4095, 8'h00, 8'hFF, 8'h00},
        1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
        1'b1, 1'b1, '{48'd16789496, 24'h00FF00, 12'd4094, 12'd4095, 1'b1}},
      '{'{REQ_TICK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd10, 12'd5, 12'd9, 12'd5, 8'hAB, 8'hCD, 8'hEF}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd7, 12'd20, 12'd7, 12'd20, 8'h10, 8'h20, 8'h30}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd4095, 12'd4094, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF},
        1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
        1'b1, 1'b1, '{48'd16785404, 24'hFFFFFF, 12'd4095, 12'd4094, 1'b1}},
      '{'{REQ_LINE_START, 12'd0, 12'd4095, 12'd2, 12'd0, 8'h01, 8'h02, 8'h03}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0},
        1'b1, 1'b1, '{48'd16773120, 24'h010203, 12'd0, 12'd4095, 1'b0}},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd100, 12'd0, 12'd100, 12'd3, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd0, 12'd100, 12'd4095, 12'd0, 8'h12, 8'h34, 8'h56}, 1'b1, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_TICK, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b0, 1'b0, '0},
      '{'{REQ_LINE_START, 12'd5, 12'd5, 12'd5, 12'd5, 8'h00, 8'h00, 8'h00}, 1'b1, 1'b0, '0}
   };

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Returns 1 when the beat produces a framebuffer write, with that write in px.
   function automatic bit next_pixel_write(input req_beat_type b, output pixel_write_type px);
      logic [CB-1:0] t_off;
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      longint        dy_val;
      longint        quot;
      logic [63:0]   sum;
      longint        y_wide;
      px = '0;
      if (b.kind == REQ_LINE_START) begin
         line_origin_x = b.start_x;
         line_origin_y = b.start_y;
         line_dx = b.end_x - b.start_x;
         line_dy = {1'b0, b.end_y} - {1'b0, b.start_y};
         line_colour = {b.red, b.green, b.blue};
         if (b.start_x != b.end_x) begin
            line_vertical = 1'b0;
            line_step = b.start_x;
            line_stop = b.end_x;
            line_active = b.end_x > b.start_x;
         end else begin
            line_vertical = 1'b1;
            line_step = b.start_y;
            line_stop = b.end_y;
            line_active = b.end_y > b.start_y;
         end
         return 1'b0;
      end
      if (!line_active) return 1'b0;
      if (line_vertical) begin
         x = line_origin_x;
         y = line_step;
      end else begin
         t_off = line_step - line_origin_x;
         dy_val = $signed(line_dy);
         quot = 0;
         // SystemVerilog division of signed values truncates toward zero.
         if (line_dx != 0) quot = (dy_val * longint'(t_off)) / longint'(line_dx);
         x = line_step;
         y_wide = longint'(line_origin_y) + quot;
         y = y_wide[CB-1:0];
      end
      sum = 64'(shadow_base) + 64'd4 * 64'(shadow_pitch) * 64'(y) + 64'd4 * 64'(x);
      line_step = line_step + 1'b1;
      px.addr = sum[AB-1:0];
      px.word = line_colour;
      px.x = x;
      px.y = y;
      px.last = (line_step == line_stop);
      if (px.last) line_active = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_beat(input req_beat_type b, output bit produced,
                            output pixel_write_type px);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_type = b.kind;
      req_start_x = b.start_x;
      req_start_y = b.start_y;
      req_end_x = b.end_x;
      req_end_y = b.end_y;
      req_red = b.red;
      req_green = b.green;
      req_blue = b.blue;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      produced = next_pixel_write(b, px);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == CSR_FRAME_BASE) shadow_base = value[AB-1:0];
      else shadow_pitch = value[PITCH_BITS-1:0];
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic csr_read_check(input csr_index_type idx);
      logic [63:0] want;
      want = (idx == CSR_FRAME_BASE) ? 64'(shadow_base) : 64'(shadow_pitch);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = {idx, 3'b000};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %s read %0h, expected %0h",
                                   idx.name(), csr_prdata, want));
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic drain_writes();
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_beat_type random_beat(input req_kind_type kind);
      req_beat_type b;
      b.kind = kind;
      b.start_x = CB'($urandom);
      b.start_y = CB'($urandom);
      b.end_x = CB'($urandom);
      b.end_y = CB'($urandom);
      b.red = CHAN_BITS'($urandom);
      b.green = CHAN_BITS'($urandom);
      b.blue = CHAN_BITS'($urandom);
      return b;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("line_pixel_generator_core_tb failed");
      $finish;
   end

   // Response stall: random bursts, or a long hold-off while the pressure
   // process asks for one.
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall = 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Hold the response side for a long stretch so the request side backs up.
   initial begin
      while (beats_counted < 130) @(posedge clock);
      hold_off = 1'b1;
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_writes.size() == 0) begin
            report_mismatch($sformatf("unexpected write beat x=%0d y=%0d addr=%0h",
                                      rsp_pixel_x, rsp_pixel_y, rsp_write_address));
         end else begin
            oldest_write = pending_writes.pop_front();
            if (rsp_write_address !== oldest_write.addr)
               report_mismatch($sformatf("write_address %0h, expected %0h",
                                         rsp_write_address, oldest_write.addr));
            if (rsp_write_word !== oldest_write.word)
               report_mismatch($sformatf("write_word %0h, expected %0h",
                                         rsp_write_word, oldest_write.word));
            if (rsp_pixel_x !== oldest_write.x)
               report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                         rsp_pixel_x, oldest_write.x));
            if (rsp_pixel_y !== oldest_write.y)
               report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                         rsp_pixel_y, oldest_write.y));
            if (rsp_last_pixel !== oldest_write.last)
               report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                         rsp_last_pixel, oldest_write.last));
         end
      end
   end

   initial begin
      logic [63:0]     base_vals [0:4];
      logic [63:0]     pitch_vals [0:4];
      req_beat_type    b;
      pixel_write_type px;
      bit              produced;
      int              phase;
      int              shape;
      int              len;
      int              sx;
      int              sy;
      int              ex;
      int              ey;
      int              span;
      int              ticks;

      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_LINE_START;
      req_start_x = '0;
      req_start_y = '0;
      req_end_x = '0;
      req_end_y = '0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      shadow_base = '0;
      shadow_pitch = PITCH_RESET;
      line_active = 1'b0;
      line_vertical = 1'b0;
      line_step = '0;
      line_origin_x = '0;
      line_origin_y = '0;
      line_stop = '0;
      line_dx = '0;
      line_dy = '0;
      line_colour = '0;

      base_vals[0] = 64'hFFFF_FFFF_FFFF_FFFF;
      pitch_vals[0] = 64'd8191;
      base_vals[1] = 64'h0;
      pitch_vals[1] = 64'd0;
      base_vals[2] = 64'hABCD_0000_0010_0000;
      pitch_vals[2] = 64'h1_0000_0001;
      base_vals[3] = {$urandom, $urandom};
      pitch_vals[3] = 64'd4096;
      base_vals[4] = 64'h0000_FFFF_FFFF_F000;
      pitch_vals[4] = 64'(PITCH_RESET);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_read_check(CSR_FRAME_BASE);
      csr_read_check(CSR_LINE_PITCH);

      for (int r = 0; r < DIR_ROWS; r++) begin
         send_beat(directed_rows[r].beat, produced, px);
         if (directed_rows[r].fixed) begin
            if (directed_rows[r].has_write) pending_writes.push_back(directed_rows[r].px);
         end else if (produced) begin
            pending_writes.push_back(px);
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         @(negedge clock);
         req_valid = 1'b0;
         drain_writes();
         csr_write(CSR_FRAME_BASE, base_vals[phase]);
         csr_write(CSR_LINE_PITCH, pitch_vals[phase]);
         csr_read_check(CSR_FRAME_BASE);
         csr_read_check(CSR_LINE_PITCH);
         while (beats_counted < (phase + 1) * PHASE_BEATS) begin
            if (beats_counted >= RANDOM_BEATS - 60) quiet = 1'b1;
            shape = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
            if (shape < 10) begin
               b = random_beat(req_kind_type'($urandom_range(0, 1)));
               send_beat(b, produced, px);
               if (produced) pending_writes.push_back(px);
               if (produced || b.kind == REQ_LINE_START) beats_counted++;
               continue;
            end
            b = random_beat(REQ_LINE_START);
            if (shape < 60) begin
               sx = $urandom_range(0, 4094);
               ex = (sx + len > 4095) ? 4095 : sx + len;
               sy = $urandom_range(0, 4095);
               ey = $urandom_range(0, 4095);
               span = ex - sx;
            end else if (shape < 85) begin
               sx = $urandom_range(0, 4095);
               ex = sx;
               sy = $urandom_range(0, 4094);
               ey = (sy + len > 4095) ? 4095 : sy + len;
               span = ey - sy;
            end else if (shape < 93) begin
               sx = $urandom_range(1, 4095);
               ex = $urandom_range(0, sx - 1);
               sy = $urandom_range(0, 4095);
               ey = $urandom_range(0, 4095);
               span = 0;
            end else begin
               sx = $urandom_range(0, 4095);
               ex = sx;
               sy = $urandom_range(0, 4095);
               ey = $urandom_range(0, sy);
               span = 0;
            end
            b.start_x = sx[CB-1:0];
            b.start_y = sy[CB-1:0];
            b.end_x = ex[CB-1:0];
            b.end_y = ey[CB-1:0];
            send_beat(b, produced, px);
            beats_counted++;
            // Mostly run the line out, sometimes cut it short with the next start.
            if (span == 0) ticks = $urandom_range(0, 3);
            else if ($urandom_range(0, 4) == 0) ticks = $urandom_range(0, span);
            else ticks = span + $urandom_range(0, 2);
            repeat (ticks) begin
               send_beat(random_beat(REQ_TICK), produced, px);
               if (produced) begin
                  pending_writes.push_back(px);
                  beats_counted++;
               end
            end
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      drain_writes();
      if (mismatch_count == 0) begin
         $display("line_pixel_generator_core_tb passed");
      end else begin
         $display("line_pixel_generator_core_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/lpg_pkg.sv
rtl/lpg_queue.sv
rtl/lpg_front.sv
rtl/lpg_back.sv
rtl/line_pixel_generator_core.sv
bench/line_pixel_generator_core_tb.sv
